// ----- rtl/lgs_pkg.sv -----
`default_nettype none

package lgs_pkg;

	// grid size defaults
	localparam int ROWS_DEF = 90;
	localparam int COLS_DEF = 160;

	// command field widths
	localparam int OP_W  = 2;
	localparam int ROW_W = 7;
	localparam int COL_W = 8;

	// command codes
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	// b3/s23 neighbor counts
	localparam logic [3:0] BIRTH_N   = 4'd3;
	localparam logic [3:0] SURVIVE_N = 4'd2;

endpackage

`default_nettype wire

// ----- rtl/lgs_cmd_if.sv -----
`default_nettype none

interface lgs_cmd_if import lgs_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;
	logic             value;

	modport source (output valid, output op, output row, output col, output value,
		input ready);
	modport sink (input valid, input op, input row, input col, input value,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/lgs_res_if.sv -----
`default_nettype none

interface lgs_res_if;
	logic valid;
	logic ready;
	logic alive;
	logic lives_next;

	modport source (output valid, output alive, output lives_next, input ready);
	modport sink (input valid, input alive, input lives_next, output ready);
endinterface

`default_nettype wire

// ----- rtl/lgs_row_rule.sv -----
`default_nettype none

module lgs_row_rule import lgs_pkg::*; #(
	parameter int COLS = COLS_DEF
) (
	input  wire logic [COLS-1:0] above,
	input  wire logic [COLS-1:0] cur,
	input  wire logic [COLS-1:0] below,
	output logic      [COLS-1:0] nxt
);

	// rows padded with a dead cell at each edge
	logic [COLS+1:0] ap;
	logic [COLS+1:0] cp;
	logic [COLS+1:0] bp;

	assign ap = {1'b0, above, 1'b0};
	assign cp = {1'b0, cur, 1'b0};
	assign bp = {1'b0, below, 1'b0};

	// one neighbor count and rule per cell
	for (genvar c = 0; c < COLS; c++) begin : g_cell
		logic [3:0] cnt;

		assign cnt = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2])
			+ 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2])
			+ 4'(cp[c]) + 4'(cp[c+2]);
		assign nxt[c] = (cnt == BIRTH_N) || (cp[c+1] && (cnt == SURVIVE_N));
	end

endmodule

`default_nettype wire

// ----- rtl/life_grid_generation_step_core.sv -----
// channel | dir | beat payload             | handshake
// cmd     | in  | op, row, col, value      | valid / ready
// res     | out | alive, lives_next        | valid / ready
//
// one command at a time; the grid lives in a row-wide memory, one row per entry
// write: accept, row read, modify/write, result; read: three row reads, then the result
// advance: a sweep of one row read and one row write per cycle
// reset marks every row invalid, and an invalid row reads as all dead; no clearing pass
// a result waiting on res holds only the result register; the next command is accepted

`default_nettype none

module life_grid_generation_step_core import lgs_pkg::*; #(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	lgs_cmd_if.sink   cmd,
	lgs_res_if.source res
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam int PW = $clog2(ROWS + 4);
	localparam int SW = $clog2(ROWS + 2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]      state_q;
	logic [OP_W-1:0] op_q;
	logic [CW-1:0]   col_q;
	logic            value_q;
	logic [RW-1:0]   wrow_q;
	logic [PW-1:0]   ptr_q;
	logic [SW-1:0]   step_q;
	logic [COLS-1:0] above_q;
	logic [COLS-1:0] cur_q;
	logic [COLS-1:0] rd_data_s1;
	logic            rd_vld_s1;
	logic [ROWS-1:0] rowv_q;
	logic            res_alive_q;
	logic            res_next_q;
	logic            out_valid_q;
	logic            out_alive_q;
	logic            out_next_q;

	logic            cmd_acc;
	logic            in_range;
	logic            rd_en;
	logic [RW-1:0]   rd_addr;
	logic [COLS-1:0] below;
	logic [COLS-1:0] nxt_row;
	logic            last_step;
	logic            mem_we;
	logic [RW-1:0]   mem_wa;
	logic [COLS-1:0] mem_wd;
	logic            out_free;

	logic [COLS-1:0] grid_mem [ROWS];

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign in_range  = (int'(cmd.row) < ROWS) && (int'(cmd.col) < COLS);

	assign res.valid      = out_valid_q;
	assign res.alive      = out_alive_q;
	assign res.lives_next = out_next_q;
	assign out_free       = !out_valid_q || res.ready;

	// row read issue, pointer is row address plus one
	assign rd_en   = (state_q == ST_RUN) && (ptr_q != '0) && (int'(ptr_q) <= ROWS);
	assign rd_addr = RW'(ptr_q - PW'(1));
	assign below   = rd_vld_s1 ? rd_data_s1 : '0;

	lgs_row_rule #(
		.COLS(COLS)
	) u_rule (
		.above(above_q),
		.cur  (cur_q),
		.below(below),
		.nxt  (nxt_row)
	);

	// end of the current command's sweep
	always_comb begin
		last_step = 1'b0;
		case (op_q)
			OP_WRITE:   last_step = (step_q == SW'(1));
			OP_READ:    last_step = (step_q == SW'(3));
			OP_ADVANCE: last_step = (step_q == SW'(ROWS + 1));
			default:    last_step = 1'b1;
		endcase
	end

	// write port: next-generation row on advance, modified row on write
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wrow_q;
		mem_wd = below;
		if (state_q == ST_RUN) begin
			if (op_q == OP_ADVANCE) begin
				mem_we = (step_q >= SW'(2));
				mem_wa = RW'(ptr_q - PW'(3));
				mem_wd = nxt_row;
			end else if (op_q == OP_WRITE) begin
				mem_we = (step_q == SW'(1));
				mem_wd[col_q] = value_q;
			end
		end
	end

	// grid memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_s1 <= grid_mem[rd_addr];
		end
	end

	// row valid bits and read qualifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowv_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				rowv_q[mem_wa] <= 1'b1;
			end
			rd_vld_s1 <= rd_en && rowv_q[rd_addr];
		end
	end

	// command payload and row window
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q        <= cmd.op;
			col_q       <= CW'(cmd.col);
			value_q     <= cmd.value;
			wrow_q      <= RW'(cmd.row);
			step_q      <= '0;
			above_q     <= '0;
			cur_q       <= '0;
			res_alive_q <= 1'b0;
			res_next_q  <= 1'b0;
			ptr_q       <= PW'(1);
			if (cmd.op == OP_WRITE) begin
				ptr_q <= PW'(cmd.row) + PW'(1);
			end else if (cmd.op == OP_READ) begin
				ptr_q <= PW'(cmd.row);
			end
		end else if (state_q == ST_RUN) begin
			ptr_q   <= ptr_q + PW'(1);
			step_q  <= step_q + SW'(1);
			above_q <= cur_q;
			cur_q   <= below;
			if (last_step && (op_q == OP_READ)) begin
				res_alive_q <= cur_q[col_q];
				res_next_q  <= nxt_row[col_q];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if ((cmd.op == OP_ADVANCE) ||
							(((cmd.op == OP_WRITE) || (cmd.op == OP_READ)) && in_range)) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RUN: begin
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_alive_q <= res_alive_q;
			out_next_q  <= res_next_q;
		end
	end

`ifndef ASSERT_OFF
	// an advance writes a row only after it was read
	a_adv_read_first: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (op_q == OP_ADVANCE)) |-> $past(rd_en, 2))
		else $error("advance wrote a row that was not read");

	// no read and write of the same row in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && mem_we) |-> (rd_addr != mem_wa))
		else $error("read and write hit the same row");

	// a new result comes only out of the done state
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside done");

	// sweep counter stays within the advance length
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= SW'(ROWS + 1)))
		else $error("sweep ran past the last row");
`endif

endmodule

`default_nettype wire

// ----- verif/life_grid_check_pkg.sv -----
`default_nettype none

package life_grid_check_pkg;
	import lgs_pkg::*;

	// the op code the block leaves unused
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// one result beat
	typedef struct packed {
		logic alive;
		logic lives_next;
	} cell_result_t;

	// predicts every result beat from the commands the block accepts
	class life_grid_scoreboard;
		bit [COLS_DEF-1:0] cells [ROWS_DEF];
		cell_result_t      pending_results[$];
		int unsigned       mismatches;

		function new();
			foreach (cells[r])
				cells[r] = '0;
			mismatches = 0;
		endfunction

		function int unsigned pending_count();
			return pending_results.size();
		endfunction

		// live cells around one cell, off-grid counts as dead
		function int live_neighbors(int r, int c);
			int n;
			n = 0;
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS_DEF &&
							c + dc >= 0 && c + dc < COLS_DEF)
						n += cells[r + dr][c + dc];
				end
			end
			return n;
		endfunction

		// birth on exactly three, survival on two or three
		function bit b3s23(bit self, int n);
			if (self)
				return n == SURVIVE_N || n == BIRTH_N;
			return n == BIRTH_N;
		endfunction

		// whole grid steps at once from the old generation
		function void step_generation();
			bit [COLS_DEF-1:0] next_cells [ROWS_DEF];
			for (int r = 0; r < ROWS_DEF; r++) begin
				for (int c = 0; c < COLS_DEF; c++)
					next_cells[r][c] = b3s23(cells[r][c], live_neighbors(r, c));
			end
			cells = next_cells;
		endfunction

		// apply one accepted command and queue the result it causes
		function void note_command(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
				logic [COL_W-1:0] col, logic value);
			cell_result_t outcome;
			bit on_grid;
			outcome = '0;
			on_grid = row < ROWS_DEF && col < COLS_DEF;
			case (op)
				OP_WRITE: begin
					if (on_grid)
						cells[row][col] = value;
				end
				OP_READ: begin
					if (on_grid) begin
						outcome.alive = cells[row][col];
						outcome.lives_next = b3s23(cells[row][col], live_neighbors(row, col));
					end
				end
				OP_ADVANCE: begin
					step_generation();
				end
				default: ;
			endcase
			pending_results.push_back(outcome);
		endfunction

		// compare one result beat with the oldest prediction
		function void check_result(logic alive, logic lives_next);
			cell_result_t wanted;
			if (pending_results.size() == 0) begin
				$error("result beat with no command waiting: alive %0d lives_next %0d",
					alive, lives_next);
				mismatches++;
				return;
			end
			wanted = pending_results.pop_front();
			if (alive !== wanted.alive) begin
				$error("alive: expected %0d, got %0d", wanted.alive, alive);
				mismatches++;
			end
			if (lives_next !== wanted.lives_next) begin
				$error("lives_next: expected %0d, got %0d", wanted.lives_next, lives_next);
				mismatches++;
			end
		endfunction
	endclass

endpackage

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

module testbench;
	import lgs_pkg::*;
	import life_grid_check_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN          = 8;
	localparam int RANDOM_ITEMS = 1100;
	localparam int QUIET_LIMIT  = 1000;

	logic clk;
	logic arst_n;

	lgs_cmd_if cmd ();
	lgs_res_if res ();

	life_grid_generation_step_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	life_grid_scoreboard grid_model = new();

	int unsigned commands_sent = 0;
	int unsigned burst_left = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	int unsigned quiet_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// send one command beat, opening a gap first when the burst is used up
	task automatic issue_command(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic value);
		if (burst_left == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.row <= row;
		cmd.col <= col;
		cmd.value <= value;
		do
			@(posedge clk);
		while (!cmd.ready);
		grid_model.note_command(op, row, col, value);
		commands_sent++;
	endtask

	// hold off until every predicted result has come back
	task automatic drain_results();
		cmd.valid <= 1'b0;
		do
			@(posedge clk);
		while (grid_model.pending_count() != 0);
	endtask

	// window origin, biased toward the grid edges
	function automatic int pick_origin(int extent);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return extent - WIN;
			default: return $urandom_range(0, extent - WIN);
		endcase
	endfunction

	// result side: check beats, stall on its own pattern
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			grid_model.check_result(res.alive, res.lives_next);
		if (calm_left > 0) begin
			calm_left--;
			res.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
			case ($urandom_range(0, 9))
				0: calm_left = $urandom_range(20, 150);
				1, 2: stall_left = $urandom_range(1, 8);
				default: ;
			endcase
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int base_row;
		int base_col;
		int unsigned random_start;

		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = OP_WRITE;
		cmd.row = '0;
		cmd.col = '0;
		cmd.value = 1'b0;
		res.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cluster: a birth and a survivor
		issue_command(OP_WRITE, 7'd0, 8'd0, 1'b1);
		issue_command(OP_WRITE, 7'd0, 8'd1, 1'b1);
		issue_command(OP_WRITE, 7'd1, 8'd0, 1'b1);
		issue_command(OP_READ, 7'd1, 8'd1, 1'b0);
		issue_command(OP_READ, 7'd0, 8'd0, 1'b0);
		// lonely cell at the far corner dies
		issue_command(OP_WRITE, 7'(ROWS_DEF - 1), 8'(COLS_DEF - 1), 1'b1);
		issue_command(OP_READ, 7'(ROWS_DEF - 1), 8'(COLS_DEF - 1), 1'b0);
		issue_command(OP_WRITE, 7'd0, 8'(COLS_DEF - 1), 1'b1);
		issue_command(OP_WRITE, 7'(ROWS_DEF - 1), 8'd0, 1'b1);
		// off-grid writes and reads
		issue_command(OP_WRITE, 7'(ROWS_DEF), 8'd5, 1'b1);
		issue_command(OP_WRITE, 7'd5, 8'(COLS_DEF), 1'b1);
		issue_command(OP_WRITE, 7'h7f, 8'hff, 1'b1);
		issue_command(OP_READ, 7'(ROWS_DEF), 8'd5, 1'b0);
		issue_command(OP_READ, 7'd5, 8'(COLS_DEF), 1'b0);
		issue_command(OP_READ, 7'h7f, 8'hff, 1'b0);
		// unused op code
		issue_command(OP_UNUSED, 7'd0, 8'd0, 1'b1);
		// blinker in the middle flips through one generation
		issue_command(OP_WRITE, 7'd45, 8'd78, 1'b1);
		issue_command(OP_WRITE, 7'd45, 8'd79, 1'b1);
		issue_command(OP_WRITE, 7'd45, 8'd80, 1'b1);
		issue_command(OP_READ, 7'd44, 8'd79, 1'b0);
		issue_command(OP_READ, 7'd45, 8'd79, 1'b0);
		issue_command(OP_ADVANCE, 7'd0, 8'd0, 1'b0);
		issue_command(OP_READ, 7'd44, 8'd79, 1'b0);
		issue_command(OP_READ, 7'd45, 8'd78, 1'b0);
		issue_command(OP_ADVANCE, 7'h7f, 8'hff, 1'b1);
		drain_results();

		// random part: colonies in small windows, plus some noise
		random_start = commands_sent;
		while (commands_sent - random_start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				base_row = pick_origin(ROWS_DEF);
				base_col = pick_origin(COLS_DEF);
				repeat ($urandom_range(6, 20))
					issue_command(OP_WRITE, ROW_W'(base_row + $urandom_range(0, WIN - 1)),
						COL_W'(base_col + $urandom_range(0, WIN - 1)),
						$urandom_range(0, 99) < 85);
				repeat ($urandom_range(1, 4)) begin
					// reads reach one cell past the window, off-grid at the edges
					repeat ($urandom_range(2, 8))
						issue_command(OP_READ, ROW_W'(base_row + $urandom_range(0, WIN + 1) - 1),
							COL_W'(base_col + $urandom_range(0, WIN + 1) - 1), 1'($urandom));
					issue_command(OP_ADVANCE, ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
				end
			end else begin
				repeat ($urandom_range(3, 10))
					issue_command(OP_W'($urandom_range(0, 3)), ROW_W'($urandom),
						COL_W'($urandom), 1'($urandom));
			end
			if ($urandom_range(0, 19) == 0)
				drain_results();
		end
		cmd.valid <= 1'b0;

		// wait out the last results, then a full sweep more
		while (grid_model.pending_count() != 0)
			@(posedge clk);
		repeat (ROWS_DEF + 10) @(posedge clk);
		if (grid_model.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
